// ===== hdl/lidar_sector_range_summary_macros.svh =====
// assertion macros for the lidar sector range summary block
// depends on nothing; included by the top level only
`ifndef LIDAR_SECTOR_RANGE_SUMMARY_MACROS_SVH
`define LIDAR_SECTOR_RANGE_SUMMARY_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define LSRS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsrs same-cycle check failed");

// next-cycle implication, checked at every rising edge out of reset
`define LSRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsrs next-cycle check failed");

`endif

// ===== hdl/lsrs_pkg.sv =====
// shared types, constants and codes for the lidar sector range summary block
// depends on nothing; imported by every module of the block
`default_nettype none

package lsrs_pkg;

   // field widths
   localparam int RANGE_W     = 16;
   localparam int CFG_W       = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int EMPTY_W     = 3;
   localparam int STATUS_W    = 2;

   // scan length limits
   localparam int MAX_POINTS_DEFAULT = 1024;
   localparam int MAX_POINTS_LIMIT   = 4096;

   // accumulator widths sized for the longest allowed scan
   localparam int CNT_W = $clog2(MAX_POINTS_LIMIT + 1);
   localparam int SUM_W = RANGE_W + CNT_W;

   // divider widths: dividend holds a sum or a mean shifted up by 16
   localparam int DEN_W = RANGE_W;
   localparam int DIV_W = (SUM_W > 2 * RANGE_W) ? SUM_W : 2 * RANGE_W;

   // scan summary queue
   localparam int QUEUE_DEPTH = 2;

   // sector bound reset values
   localparam logic [CFG_W-1:0] LEFT_START_RST    = CFG_W'(390);
   localparam logic [CFG_W-1:0] LEFT_END_RST      = CFG_W'(450);
   localparam logic [CFG_W-1:0] RIGHT_START_RST   = CFG_W'(270);
   localparam logic [CFG_W-1:0] RIGHT_END_RST     = CFG_W'(330);
   localparam logic [CFG_W-1:0] FORWARD_START_RST = CFG_W'(330);
   localparam logic [CFG_W-1:0] FORWARD_END_RST   = CFG_W'(390);

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALL_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEFT_START    = 3'd0,
      CSR_LEFT_END      = 3'd1,
      CSR_RIGHT_START   = 3'd2,
      CSR_RIGHT_END     = 3'd3,
      CSR_FORWARD_START = 3'd4,
      CSR_FORWARD_END   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] left_start;
      logic [CFG_W-1:0] left_end;
      logic [CFG_W-1:0] right_start;
      logic [CFG_W-1:0] right_end;
      logic [CFG_W-1:0] forward_start;
      logic [CFG_W-1:0] forward_end;
   } cfg_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic               last;
   } req_payload_type;

   typedef struct packed {
      logic [RANGE_W-1:0]  peak_mm;
      logic [CFG_W-1:0]    max_direction;
      logic [RANGE_W-1:0]  left_mean;
      logic [RANGE_W-1:0]  left_mean_norm;
      logic [RANGE_W-1:0]  forward_mean;
      logic [RANGE_W-1:0]  forward_mean_norm;
      logic [RANGE_W-1:0]  right_mean;
      logic [RANGE_W-1:0]  right_mean_norm;
      logic [EMPTY_W-1:0]  empty_sectors;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   // totals of one finished scan, handed from front to back
   typedef struct packed {
      logic [RANGE_W-1:0] peak_range;
      logic [CFG_W-1:0]   peak_index;
      logic [SUM_W-1:0]   left_sum;
      logic [SUM_W-1:0]   forward_sum;
      logic [SUM_W-1:0]   right_sum;
      logic [CNT_W-1:0]   left_count;
      logic [CNT_W-1:0]   forward_count;
      logic [CNT_W-1:0]   right_count;
      logic               overflowed;
   } scan_sum_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_START,
      BACK_BUSY,
      BACK_HOLD
   } back_state_type;

   typedef enum logic [2:0] {
      STEP_LEFT_MEAN,
      STEP_FORWARD_MEAN,
      STEP_RIGHT_MEAN,
      STEP_LEFT_NORM,
      STEP_FORWARD_NORM,
      STEP_RIGHT_NORM
   } step_type;

endpackage

`default_nettype wire

// ===== hdl/lsrs_front.sv =====
// front end: takes range samples, tracks the peak and per-sector totals
// depends on lsrs_pkg; pushes one scan summary per scan into lsrs_queue
`default_nettype none

module lsrs_front
   import lsrs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cfg_type         cfg,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   input  wire logic            q_full,
   output logic                 q_push,
   output scan_sum_type         q_push_data
);

   localparam int IDX_W = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;

   logic [IDX_W-1:0]   sample_index_ff, sample_index_in;
   logic [RANGE_W-1:0] peak_range_ff, peak_range_in;
   logic [CFG_W-1:0]   peak_index_ff, peak_index_in;
   logic [SUM_W-1:0]   left_sum_ff, left_sum_in;
   logic [SUM_W-1:0]   forward_sum_ff, forward_sum_in;
   logic [SUM_W-1:0]   right_sum_ff, right_sum_in;
   logic [CNT_W-1:0]   left_count_ff, left_count_in;
   logic [CNT_W-1:0]   forward_count_ff, forward_count_in;
   logic [CNT_W-1:0]   right_count_ff, right_count_in;
   logic               overflowed_ff, overflowed_in;

   logic               accept;
   logic               in_span;
   logic               nonzero;
   logic [CMP_W-1:0]   idx_ext;
   logic               hit_left;
   logic               hit_right;
   logic               hit_forward;

   // hold off new beats while the summary queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // sector classification of the current index
   always_comb begin
      idx_ext     = CMP_W'(sample_index_ff);
      in_span     = sample_index_ff < IDX_W'(MAX_POINTS);
      nonzero     = |req_data.range_mm;
      hit_left    = (idx_ext >= CMP_W'(cfg.left_start)) && (idx_ext < CMP_W'(cfg.left_end));
      hit_right   = (idx_ext > CMP_W'(cfg.right_start)) && (idx_ext <= CMP_W'(cfg.right_end));
      hit_forward = (idx_ext >= CMP_W'(cfg.forward_start))
                    && (idx_ext <= CMP_W'(cfg.forward_end));
   end

   // scan state after this beat
   always_comb begin
      sample_index_in  = sample_index_ff;
      peak_range_in    = peak_range_ff;
      peak_index_in    = peak_index_ff;
      left_sum_in      = left_sum_ff;
      forward_sum_in   = forward_sum_ff;
      right_sum_in     = right_sum_ff;
      left_count_in    = left_count_ff;
      forward_count_in = forward_count_ff;
      right_count_in   = right_count_ff;
      overflowed_in    = overflowed_ff;
      if (!in_span) begin
         overflowed_in = 1'b1;
      end else begin
         sample_index_in = sample_index_ff + 1'b1;
         if (req_data.range_mm > peak_range_ff) begin
            peak_range_in = req_data.range_mm;
            peak_index_in = idx_ext[CFG_W-1:0];
         end
         if (nonzero) begin
            priority if (hit_left) begin
               left_sum_in   = left_sum_ff + SUM_W'(req_data.range_mm);
               left_count_in = left_count_ff + 1'b1;
            end else if (hit_right) begin
               right_sum_in   = right_sum_ff + SUM_W'(req_data.range_mm);
               right_count_in = right_count_ff + 1'b1;
            end else if (hit_forward) begin
               forward_sum_in   = forward_sum_ff + SUM_W'(req_data.range_mm);
               forward_count_in = forward_count_ff + 1'b1;
            end
         end
      end
   end

   // scan registers, cleared after the last beat of a scan
   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last)) begin
         sample_index_ff  <= '0;
         peak_range_ff    <= '0;
         peak_index_ff    <= '0;
         left_sum_ff      <= '0;
         forward_sum_ff   <= '0;
         right_sum_ff     <= '0;
         left_count_ff    <= '0;
         forward_count_ff <= '0;
         right_count_ff   <= '0;
         overflowed_ff    <= 1'b0;
      end else if (accept) begin
         sample_index_ff  <= sample_index_in;
         peak_range_ff    <= peak_range_in;
         peak_index_ff    <= peak_index_in;
         left_sum_ff      <= left_sum_in;
         forward_sum_ff   <= forward_sum_in;
         right_sum_ff     <= right_sum_in;
         left_count_ff    <= left_count_in;
         forward_count_ff <= forward_count_in;
         right_count_ff   <= right_count_in;
         overflowed_ff    <= overflowed_in;
      end
   end

   // summary of the finished scan, including its last beat
   assign q_push                    = accept && req_data.last;
   assign q_push_data.peak_range    = peak_range_in;
   assign q_push_data.peak_index    = peak_index_in;
   assign q_push_data.left_sum      = left_sum_in;
   assign q_push_data.forward_sum   = forward_sum_in;
   assign q_push_data.right_sum     = right_sum_in;
   assign q_push_data.left_count    = left_count_in;
   assign q_push_data.forward_count = forward_count_in;
   assign q_push_data.right_count   = right_count_in;
   assign q_push_data.overflowed    = overflowed_in;

endmodule

`default_nettype wire

// ===== hdl/lsrs_queue.sv =====
// small fifo of scan summaries between the front and back ends
// depends on lsrs_pkg
`default_nettype none

module lsrs_queue
   import lsrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire scan_sum_type push_data,
   input  wire logic         pop,
   output scan_sum_type      head_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   scan_sum_type     entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full      = count_ff == (PTR_W + 1)'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_data = entries_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lsrs_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on lsrs_pkg; shared by all six divisions of the back end
`default_nettype none

module lsrs_div
   import lsrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNT_BITS = $clog2(DIV_W);

   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]    den_ff;
   logic [CNT_BITS-1:0] bit_cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [DEN_W:0]      trial;
   logic [DEN_W:0]      diff;

   // one shift-and-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, den_ff};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = diff[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b0};
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         den_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff    <= 1'b1;
            bit_cnt_ff <= '0;
         end else if (busy_ff) begin
            bit_cnt_ff <= bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == CNT_BITS'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/lsrs_back.sv =====
// back end: turns a scan summary into means and normalized means
// depends on lsrs_pkg; drives lsrs_div and owns the result register
`default_nettype none

module lsrs_back
   import lsrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_empty,
   input  wire scan_sum_type q_head,
   output logic              q_pop,
   output div_req_type       div_req,
   input  wire div_rsp_type  div_rsp,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_payload_type   rsp_data
);

   back_state_type     state_ff, state_in;
   step_type           step_ff;
   scan_sum_type       sum_ff;
   logic [RANGE_W-1:0] left_mean_ff, forward_mean_ff, right_mean_ff;
   logic [RANGE_W-1:0] left_norm_ff, forward_norm_ff, right_norm_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   logic               load_out;
   logic               div_start;
   logic               last_step;
   logic [CNT_W-1:0]   sel_count;
   logic [RANGE_W-1:0] mean_q;
   logic [RANGE_W-1:0] norm_q;

   assign last_step = step_ff == STEP_RIGHT_NORM;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               state_in = BACK_START;
            end
         end
         BACK_START: begin
            state_in = BACK_BUSY;
         end
         BACK_BUSY: begin
            if (div_rsp.done) begin
               state_in = last_step ? BACK_HOLD : BACK_START;
            end
         end
         BACK_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = (state_ff == BACK_IDLE) && !q_empty;
      div_start = state_ff == BACK_START;
      load_out  = (state_ff == BACK_HOLD) && (!rsp_valid_ff || !rsp_stall);
   end

   // divider operands for the current step
   always_comb begin
      div_req.start    = div_start;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      sel_count        = '0;
      unique case (step_ff)
         STEP_LEFT_MEAN: begin
            div_req.dividend = DIV_W'(sum_ff.left_sum);
            div_req.divisor  = DEN_W'(sum_ff.left_count);
            sel_count        = sum_ff.left_count;
         end
         STEP_FORWARD_MEAN: begin
            div_req.dividend = DIV_W'(sum_ff.forward_sum);
            div_req.divisor  = DEN_W'(sum_ff.forward_count);
            sel_count        = sum_ff.forward_count;
         end
         STEP_RIGHT_MEAN: begin
            div_req.dividend = DIV_W'(sum_ff.right_sum);
            div_req.divisor  = DEN_W'(sum_ff.right_count);
            sel_count        = sum_ff.right_count;
         end
         STEP_LEFT_NORM: begin
            div_req.dividend = DIV_W'({left_mean_ff, {RANGE_W{1'b0}}});
            div_req.divisor  = sum_ff.peak_range;
         end
         STEP_FORWARD_NORM: begin
            div_req.dividend = DIV_W'({forward_mean_ff, {RANGE_W{1'b0}}});
            div_req.divisor  = sum_ff.peak_range;
         end
         STEP_RIGHT_NORM: begin
            div_req.dividend = DIV_W'({right_mean_ff, {RANGE_W{1'b0}}});
            div_req.divisor  = sum_ff.peak_range;
         end
         default: begin
            div_req.dividend = '0;
         end
      endcase
   end

   // empty sector gives zero, zero peak gives zero, a full ratio saturates
   always_comb begin
      mean_q = (sel_count == '0) ? '0 : div_rsp.quotient[RANGE_W-1:0];
      if (sum_ff.peak_range == '0) begin
         norm_q = '0;
      end else if (|div_rsp.quotient[DIV_W-1:RANGE_W]) begin
         norm_q = '1;
      end else begin
         norm_q = div_rsp.quotient[RANGE_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         step_ff      <= STEP_LEFT_MEAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop) begin
            step_ff <= STEP_LEFT_MEAN;
         end else if ((state_ff == BACK_BUSY) && div_rsp.done && !last_step) begin
            step_ff <= step_type'(step_ff + 1'b1);
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // summary capture and division results
   always_ff @(posedge clock) begin
      if (q_pop) begin
         sum_ff <= q_head;
      end
      if ((state_ff == BACK_BUSY) && div_rsp.done) begin
         unique case (step_ff)
            STEP_LEFT_MEAN:    left_mean_ff    <= mean_q;
            STEP_FORWARD_MEAN: forward_mean_ff <= mean_q;
            STEP_RIGHT_MEAN:   right_mean_ff   <= mean_q;
            STEP_LEFT_NORM:    left_norm_ff    <= norm_q;
            STEP_FORWARD_NORM: forward_norm_ff <= norm_q;
            STEP_RIGHT_NORM:   right_norm_ff   <= norm_q;
            default:           left_mean_ff    <= left_mean_ff;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff.peak_mm           <= sum_ff.peak_range;
         rsp_data_ff.max_direction     <= sum_ff.peak_index;
         rsp_data_ff.left_mean         <= left_mean_ff;
         rsp_data_ff.left_mean_norm    <= left_norm_ff;
         rsp_data_ff.forward_mean      <= forward_mean_ff;
         rsp_data_ff.forward_mean_norm <= forward_norm_ff;
         rsp_data_ff.right_mean        <= right_mean_ff;
         rsp_data_ff.right_mean_norm   <= right_norm_ff;
         rsp_data_ff.empty_sectors     <= {sum_ff.right_count == '0,
                                           sum_ff.forward_count == '0,
                                           sum_ff.left_count == '0};
         if (sum_ff.peak_range == '0) begin
            rsp_data_ff.status <= STATUS_ALL_ZERO;
         end else if (sum_ff.overflowed) begin
            rsp_data_ff.status <= STATUS_OVERFLOW;
         end else begin
            rsp_data_ff.status <= STATUS_OK;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lidar_sector_range_summary.sv =====
// Lidar sector range summary, top level.
// Input channel req_*: one range sample per beat, req_data.last marks the
// final sample of a scan; the beat's position in the scan is its index.
// Output channel rsp_*: one summary beat per scan (peak, sector means,
// normalized means, empty-sector flags, status).
// Config port csr_*: six 10-bit sector bounds. The user must see that they
// are written only while idle; the block itself does not enforce this.
// Throughput: one sample per cycle while req_stall is low. Each scan then
// needs six divisions in one shared radix-2 divider; a two-entry summary
// queue lets the front keep taking samples of the next scans while the back
// end works, and the front stalls only when that queue is full.
// Reset (synchronous) clears all scan state, empties the queue and loads the
// default bounds. A stalled summary beat holds in the output register while
// the back end goes on with the next scan.
// depends on lsrs_pkg, lsrs_front, lsrs_queue, lsrs_div, lsrs_back
`default_nettype none

`include "lidar_sector_range_summary_macros.svh"

module lidar_sector_range_summary
   import lsrs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_data,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata
);

   cfg_type      cfg_ff;
   logic         q_push;
   scan_sum_type q_push_data;
   logic         q_pop;
   scan_sum_type q_head;
   logic         q_full;
   logic         q_empty;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   // sector bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_start    <= LEFT_START_RST;
         cfg_ff.left_end      <= LEFT_END_RST;
         cfg_ff.right_start   <= RIGHT_START_RST;
         cfg_ff.right_end     <= RIGHT_END_RST;
         cfg_ff.forward_start <= FORWARD_START_RST;
         cfg_ff.forward_end   <= FORWARD_END_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT_START:    cfg_ff.left_start    <= csr_wdata;
            CSR_LEFT_END:      cfg_ff.left_end      <= csr_wdata;
            CSR_RIGHT_START:   cfg_ff.right_start   <= csr_wdata;
            CSR_RIGHT_END:     cfg_ff.right_end     <= csr_wdata;
            CSR_FORWARD_START: cfg_ff.forward_start <= csr_wdata;
            CSR_FORWARD_END:   cfg_ff.forward_end   <= csr_wdata;
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   lsrs_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   lsrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   lsrs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lsrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a finished scan is always waiting in the queue right after its last beat
   `LSRS_ASSERT_NEXT(a_last_queued, clock, reset, req_valid && !req_stall && req_data.last, !q_empty)

   // an all-zero scan reports a zero peak and zero normalized means
   `LSRS_ASSERT_NOW(a_all_zero, clock, reset, rsp_valid && (rsp_data.status == STATUS_ALL_ZERO), (rsp_data.peak_mm == '0) && (rsp_data.left_mean_norm == '0) && (rsp_data.forward_mean_norm == '0) && (rsp_data.right_mean_norm == '0))

   // an empty left sector reports zero mean and zero normalized mean
   `LSRS_ASSERT_NOW(a_left_empty, clock, reset, rsp_valid && rsp_data.empty_sectors[0], (rsp_data.left_mean == '0) && (rsp_data.left_mean_norm == '0))

   // a forward mean equal to the peak saturates its normalized value
   `LSRS_ASSERT_NOW(a_forward_sat, clock, reset, rsp_valid && (rsp_data.peak_mm != '0) && (rsp_data.forward_mean == rsp_data.peak_mm), rsp_data.forward_mean_norm == '1)

endmodule

`default_nettype wire
